// ===== hw/rtl/ple_pkg.sv =====
// Shared types and codes for the positional list engine.
// Holds request/result payload structs and controller-to-datapath command and status.
// No dependencies.
package ple_pkg;

    // Request kinds
    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_DELETE = 3'd1;
    localparam logic [2:0] REQ_CLEAR  = 3'd2;
    localparam logic [2:0] REQ_LOCATE = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;
    localparam logic [2:0] REQ_FIRST  = 3'd5;
    localparam logic [2:0] REQ_LAST   = 3'd6;
    localparam logic [2:0] REQ_EMPTY  = 3'd7;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Walk index update
    localparam logic [2:0] IDX_HOLD    = 3'd0;
    localparam logic [2:0] IDX_ZERO    = 3'd1;
    localparam logic [2:0] IDX_POS     = 3'd2;
    localparam logic [2:0] IDX_POS_INC = 3'd3;
    localparam logic [2:0] IDX_LAST    = 3'd4;
    localparam logic [2:0] IDX_INC     = 3'd5;
    localparam logic [2:0] IDX_DEC     = 3'd6;

    // Deferred shift write direction
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_UP   = 2'd1;
    localparam logic [1:0] PEND_DOWN = 2'd2;

    // Fill count update
    localparam logic [1:0] FILL_HOLD  = 2'd0;
    localparam logic [1:0] FILL_INC   = 2'd1;
    localparam logic [1:0] FILL_DEC   = 2'd2;
    localparam logic [1:0] FILL_CLEAR = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] item_value;
        logic [5:0]         item_position;
    } ple_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_value;
        logic [5:0]         out_position;
        logic               list_empty;
        logic [6:0]         entry_count;
    } ple_out_t;

    typedef struct packed {
        logic       req_load;
        logic [2:0] idx_sel;
        logic       rd_en;
        logic [1:0] pend_dir;
        logic       chk_en;
        logic       put_en;
        logic [1:0] fill_op;
        logic       st_load;
        logic [2:0] st_code;
        logic       val_load;
        logic       pos_load;
        logic       out_load;
    } ple_cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       full;
        logic       empty;
        logic       pos_gt_fill;
        logic       pos_ge_fill;
        logic       pos_is_end;
        logic       idx_eq_pos;
        logic       idx_is_end;
        logic       match;
    } ple_stat_t;

endpackage

// ===== hw/rtl/ple_dpath.sv =====
// Datapath of the positional list engine: entry memory, fill count, walk index,
// deferred shift write, scan compare and result registers.
// Depends on ple_pkg.
module ple_dpath
    import ple_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  ple_in_t   req_in,
    input  ple_cmd_t  cmd,
    output ple_stat_t stat,
    output ple_out_t  res_out
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int FW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((FW > 6) ? FW : 6) + 1;

    logic [31:0]        mem [CAPACITY];
    logic [31:0]        rdata_reg;

    logic [2:0]         type_reg;
    logic signed [31:0] val_reg;
    logic [5:0]         pos_reg;

    logic [FW-1:0]      fill_reg, fill_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               pend_vld_reg;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic               chk_vld_reg;
    logic [AW-1:0]      chk_idx_reg;

    logic [2:0]         st_reg;
    logic [31:0]        rval_reg;
    logic [AW-1:0]      rpos_reg;
    ple_out_t           out_reg;

    logic [CMPW-1:0]    pos_c, fill_c, idx_c;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;

    // Widen operands for range checks
    assign pos_c  = CMPW'(pos_reg);
    assign fill_c = CMPW'(fill_reg);
    assign idx_c  = CMPW'(idx_reg);

    assign stat.req_type    = type_reg;
    assign stat.full        = (fill_reg == FW'(CAPACITY));
    assign stat.empty       = (fill_reg == '0);
    assign stat.pos_gt_fill = (pos_c > fill_c);
    assign stat.pos_ge_fill = (pos_c >= fill_c);
    assign stat.pos_is_end  = ((pos_c + CMPW'(1)) == fill_c);
    assign stat.idx_eq_pos  = (idx_c == pos_c);
    assign stat.idx_is_end  = ((idx_c + CMPW'(1)) == fill_c);
    assign stat.match       = chk_vld_reg && (rdata_reg == val_reg);

    // Capture the request
    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            type_reg <= req_in.req_type;
            val_reg  <= req_in.item_value;
            pos_reg  <= req_in.item_position;
        end
    end

    // Select the next walk index
    always_comb begin
        case (cmd.idx_sel)
            IDX_HOLD:    idx_next = idx_reg;
            IDX_ZERO:    idx_next = '0;
            IDX_POS:     idx_next = AW'(pos_reg);
            IDX_POS_INC: idx_next = AW'({1'b0, pos_reg} + 7'd1);
            IDX_LAST:    idx_next = AW'(fill_reg - FW'(1));
            IDX_INC:     idx_next = idx_reg + AW'(1);
            IDX_DEC:     idx_next = idx_reg - AW'(1);
            default:     idx_next = idx_reg;
        endcase
    end

    // Target of the shift write that follows each read
    always_comb begin
        case (cmd.pend_dir)
            PEND_UP:   pend_addr_next = idx_reg + AW'(1);
            PEND_DOWN: pend_addr_next = idx_reg - AW'(1);
            default:   pend_addr_next = idx_reg;
        endcase
    end

    always_comb begin
        case (cmd.fill_op)
            FILL_INC:   fill_next = fill_reg + FW'(1);
            FILL_DEC:   fill_next = fill_reg - FW'(1);
            FILL_CLEAR: fill_next = '0;
            default:    fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            pend_vld_reg <= 1'b0;
            chk_vld_reg  <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            pend_vld_reg <= cmd.pend_dir != PEND_NONE;
            chk_vld_reg  <= cmd.chk_en;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        chk_idx_reg   <= idx_reg;
    end

    // Single write port: deferred shift write or the inserted value
    assign wr_en   = pend_vld_reg || cmd.put_en;
    assign wr_addr = cmd.put_en ? AW'(pos_reg) : pend_addr_reg;
    assign wr_data = cmd.put_en ? val_reg : rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg <= mem[idx_reg];
        end
    end

    // Result fields, cleared at each new request
    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            st_reg   <= ST_OK;
            rval_reg <= '0;
            rpos_reg <= '0;
        end else begin
            if (cmd.st_load) begin
                st_reg <= cmd.st_code;
            end
            if (cmd.val_load) begin
                rval_reg <= rdata_reg;
            end
            if (cmd.pos_load) begin
                rpos_reg <= chk_idx_reg;
            end
        end
    end

    // Output register, loaded when the result is handed over
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.status       <= st_reg;
            out_reg.out_value    <= rval_reg;
            out_reg.out_position <= 6'(rpos_reg);
            out_reg.list_empty   <= (fill_reg == '0);
            out_reg.entry_count  <= 7'(fill_reg);
        end
    end

    assign res_out = out_reg;

endmodule

// ===== hw/rtl/ple_ctrl.sv =====
// Controller of the positional list engine: request decode, shift, scan and read
// sequencing, and the input/output handshakes.
// Depends on ple_pkg.
module ple_ctrl
    import ple_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  ple_stat_t stat,
    output ple_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SHUP   = 4'd2;
    localparam logic [3:0] S_SHDN   = 4'd3;
    localparam logic [3:0] S_DRAIN  = 4'd4;
    localparam logic [3:0] S_PUT    = 4'd5;
    localparam logic [3:0] S_READ   = 4'd6;
    localparam logic [3:0] S_RWAIT  = 4'd7;
    localparam logic [3:0] S_SCAN   = 4'd8;
    localparam logic [3:0] S_SCEND  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.idx_sel  = IDX_HOLD;
        cmd.pend_dir = PEND_NONE;
        cmd.fill_op  = FILL_HOLD;
        cmd.st_code  = ST_OK;

        case (state_reg)
            // Take a request transfer
            S_IDLE: begin
                if (s_valid) begin
                    cmd.req_load = 1'b1;
                    state_next   = S_DECODE;
                end
            end

            // Check bounds and pick the walk
            S_DECODE: begin
                state_next = S_DONE;
                case (stat.req_type)
                    REQ_INSERT: begin
                        if (stat.full) begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = ST_FULL;
                        end else if (stat.pos_gt_fill) begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = ST_RANGE;
                        end else if (stat.pos_ge_fill) begin
                            state_next = S_PUT;
                        end else begin
                            cmd.idx_sel = IDX_LAST;
                            state_next  = S_SHUP;
                        end
                    end
                    REQ_DELETE: begin
                        if (stat.empty) begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = ST_EMPTY;
                        end else if (stat.pos_ge_fill) begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = ST_RANGE;
                        end else if (stat.pos_is_end) begin
                            cmd.fill_op = FILL_DEC;
                        end else begin
                            cmd.idx_sel = IDX_POS_INC;
                            state_next  = S_SHDN;
                        end
                    end
                    REQ_CLEAR: begin
                        cmd.fill_op = FILL_CLEAR;
                    end
                    REQ_LOCATE: begin
                        if (stat.empty) begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = ST_EMPTY;
                        end else begin
                            cmd.idx_sel = IDX_ZERO;
                            state_next  = S_SCAN;
                        end
                    end
                    REQ_READ: begin
                        if (stat.empty) begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = ST_EMPTY;
                        end else if (stat.pos_ge_fill) begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = ST_RANGE;
                        end else begin
                            cmd.idx_sel = IDX_POS;
                            state_next  = S_READ;
                        end
                    end
                    REQ_FIRST: begin
                        if (stat.empty) begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = ST_EMPTY;
                        end else begin
                            cmd.idx_sel = IDX_ZERO;
                            state_next  = S_READ;
                        end
                    end
                    REQ_LAST: begin
                        if (stat.empty) begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = ST_EMPTY;
                        end else begin
                            cmd.idx_sel = IDX_LAST;
                            state_next  = S_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Move entries up one slot, from the tail down to the insert point
            S_SHUP: begin
                cmd.rd_en    = 1'b1;
                cmd.pend_dir = PEND_UP;
                if (stat.idx_eq_pos) begin
                    state_next = S_DRAIN;
                end else begin
                    cmd.idx_sel = IDX_DEC;
                end
            end

            // Move entries down one slot, from past the delete point to the tail
            S_SHDN: begin
                cmd.rd_en    = 1'b1;
                cmd.pend_dir = PEND_DOWN;
                if (stat.idx_is_end) begin
                    state_next = S_DRAIN;
                end else begin
                    cmd.idx_sel = IDX_INC;
                end
            end

            // Last shift write lands this cycle
            S_DRAIN: begin
                if (stat.req_type == REQ_INSERT) begin
                    state_next = S_PUT;
                end else begin
                    cmd.fill_op = FILL_DEC;
                    state_next  = S_DONE;
                end
            end

            S_PUT: begin
                cmd.put_en  = 1'b1;
                cmd.fill_op = FILL_INC;
                state_next  = S_DONE;
            end

            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_RWAIT;
            end

            S_RWAIT: begin
                cmd.val_load = 1'b1;
                state_next   = S_DONE;
            end

            // Read one entry a cycle, compare the one read the cycle before
            S_SCAN: begin
                cmd.rd_en  = 1'b1;
                cmd.chk_en = 1'b1;
                if (stat.match) begin
                    cmd.pos_load = 1'b1;
                    state_next   = S_DONE;
                end else if (stat.idx_is_end) begin
                    state_next = S_SCEND;
                end else begin
                    cmd.idx_sel = IDX_INC;
                end
            end

            // Compare the tail entry
            S_SCEND: begin
                if (stat.match) begin
                    cmd.pos_load = 1'b1;
                end else begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_NOTFOUND;
                end
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hw/rtl/positional_list_engine.sv =====
// Positional list engine: ordered list of up to CAPACITY signed words in one memory.
// Rejects, clear, empty query and tail delete pass from decode to the result; an append adds
// a put step, reads a read and a wait step; locate, insert and delete walk one entry per
// cycle. A request is taken once the last result is handed over, which an untaken result delays.
// Reset (aresetn, synchronous, active low) empties the list; memory contents are not cleared.
// Depends on ple_pkg, ple_ctrl, ple_dpath.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ple_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ple_out_t m_data
);

    ple_cmd_t  cmd;
    ple_stat_t stat;

    ple_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ple_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_in  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .res_out (m_data)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for positional_list_engine: directed, full-list,
// back-pressure and random request traffic against an in-bench list predictor.
// Depends on ple_pkg and positional_list_engine.
module tb;
    import ple_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int DRAIN_SLACK    = CAPACITY + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_PHASE   = 300;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    ple_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    ple_out_t m_data;

    // predicted list contents and length
    logic signed [31:0] list_words [CAPACITY];
    int                 list_len;
    ple_out_t           pending_results [$];

    int error_count;
    bit send_idle_en;
    bit recv_idle_en;
    int recv_hold_cycles;
    int quiet_cycles;

    positional_list_engine #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one request to the predicted list and return the result it yields.
    function automatic ple_out_t apply_request(input ple_in_t req);
        ple_out_t res;
        int       p;
        int       i;
        res = '0;
        res.status = ST_OK;
        p = int'(req.item_position);
        case (req.req_type)
            REQ_INSERT: begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (p > list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (i = list_len; i > p; i--) list_words[i] = list_words[i - 1];
                    list_words[p] = req.item_value;
                    list_len++;
                end
            end
            REQ_DELETE: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (p >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (i = p; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
                    list_len--;
                end
            end
            REQ_CLEAR: begin
                list_len = 0;
            end
            REQ_LOCATE: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.status = ST_NOTFOUND;
                    for (i = 0; i < list_len && res.status != ST_OK; i++) begin
                        if (list_words[i] == req.item_value) begin
                            res.status = ST_OK;
                            res.out_position = 6'(i);
                        end
                    end
                end
            end
            REQ_READ: begin
                if (list_len == 0) res.status = ST_EMPTY;
                else if (p >= list_len) res.status = ST_RANGE;
                else res.out_value = list_words[p];
            end
            REQ_FIRST: begin
                if (list_len == 0) res.status = ST_EMPTY;
                else res.out_value = list_words[0];
            end
            REQ_LAST: begin
                if (list_len == 0) res.status = ST_EMPTY;
                else res.out_value = list_words[list_len - 1];
            end
            default: begin
            end
        endcase
        res.list_empty  = (list_len == 0);
        res.entry_count = 7'(list_len);
        return res;
    endfunction

    function automatic ple_in_t make_req(input logic [2:0] kind,
                                         input logic signed [31:0] value, input int pos);
        ple_in_t r;
        r.req_type      = kind;
        r.item_value    = value;
        r.item_position = 6'(pos);
        return r;
    endfunction

    // Small values in four of ten draws so that locates hit duplicates, plus extremes and full range.
    function automatic logic signed [31:0] random_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $signed($urandom_range(0, 15)) - 8;
        if (r == 4) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return -1;
                default: return 0;
            endcase
        end
        return $urandom();
    endfunction

    // Draw a mostly well-formed request, steering the list length toward target_len.
    function automatic ple_in_t random_req(input int target_len);
        logic [2:0]         kind;
        logic signed [31:0] value;
        int                 pos;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 35) kind = (list_len < target_len) ? REQ_INSERT : REQ_DELETE;
        else if (r < 50) kind = REQ_LOCATE;
        else if (r < 70) kind = REQ_READ;
        else if (r < 78) kind = REQ_FIRST;
        else if (r < 86) kind = REQ_LAST;
        else if (r < 92) kind = REQ_EMPTY;
        else if (r < 94) kind = REQ_CLEAR;
        else kind = 3'($urandom_range(0, 7));

        if ($urandom_range(0, 99) < 15) begin
            pos = $urandom_range(0, 63);
        end else if (kind == REQ_INSERT) begin
            pos = $urandom_range(0, (list_len > 63) ? 63 : list_len);
        end else begin
            pos = (list_len > 0) ? $urandom_range(0, list_len - 1) : 0;
        end

        value = random_word();
        if (kind == REQ_LOCATE && list_len > 0 && $urandom_range(0, 9) < 6) begin
            value = list_words[$urandom_range(0, list_len - 1)];
        end
        return make_req(kind, value, pos);
    endfunction

    // Offer one request, hold it until the transfer, then record its expected result.
    task automatic send_req(input ple_in_t req);
        int gap;
        gap = send_idle_en ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(apply_request(req));
    endtask

    // Drop valid and wait until every expected result has arrived.
    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic test_empty_and_small_list();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        // every request but clear on an empty list
        send_req(make_req(REQ_DELETE, 0, 0));
        send_req(make_req(REQ_READ, 0, 0));
        send_req(make_req(REQ_LOCATE, 0, 0));
        send_req(make_req(REQ_FIRST, 0, 0));
        send_req(make_req(REQ_LAST, 0, 0));
        send_req(make_req(REQ_EMPTY, 0, 0));
        send_req(make_req(REQ_INSERT, 5, 1));
        // build a short list with extreme values, append and insert in the middle
        send_req(make_req(REQ_INSERT, 32'sh7FFF_FFFF, 0));
        send_req(make_req(REQ_INSERT, 32'sh8000_0000, 0));
        send_req(make_req(REQ_INSERT, -1, 2));
        send_req(make_req(REQ_INSERT, 0, 1));
        send_req(make_req(REQ_READ, 0, 63));
        send_req(make_req(REQ_READ, 0, 0));
        send_req(make_req(REQ_READ, 0, 3));
        send_req(make_req(REQ_LOCATE, -1, 0));
        send_req(make_req(REQ_LOCATE, 12345, 0));
        send_req(make_req(REQ_FIRST, 0, 0));
        send_req(make_req(REQ_LAST, 0, 0));
        send_req(make_req(REQ_DELETE, 0, 4));
        send_req(make_req(REQ_DELETE, 0, 1));
        send_req(make_req(REQ_EMPTY, 0, 0));
        send_req(make_req(REQ_CLEAR, 0, 0));
        send_req(make_req(REQ_EMPTY, 0, 0));
        send_req(make_req(REQ_DELETE, 0, 63));
        wait_drain();
    endtask

    task automatic test_fill_to_capacity();
        int n;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        send_req(make_req(REQ_CLEAR, 0, 0));
        for (n = 0; n < CAPACITY; n++) begin
            send_req(make_req(REQ_INSERT, $urandom(), $urandom_range(0, list_len)));
        end
        // full list: inserts are refused, end entries still readable
        send_req(make_req(REQ_INSERT, 7, 0));
        send_req(make_req(REQ_INSERT, 7, 63));
        send_req(make_req(REQ_READ, 0, 63));
        send_req(make_req(REQ_LAST, 0, 0));
        send_req(make_req(REQ_FIRST, 0, 0));
        send_req(make_req(REQ_LOCATE, list_words[CAPACITY - 1], 0));
        send_req(make_req(REQ_DELETE, 0, 63));
        send_req(make_req(REQ_INSERT, -9, 63));
        send_req(make_req(REQ_DELETE, 0, 0));
        send_req(make_req(REQ_READ, 0, 63));
        // empty it again by deletes at random positions
        while (list_len > 0) begin
            send_req(make_req(REQ_DELETE, 0, $urandom_range(0, list_len - 1)));
            if ((list_len % 8) == 0 && list_len > 0) begin
                send_req(make_req(REQ_LOCATE, list_words[$urandom_range(0, list_len - 1)], 0));
            end
        end
        send_req(make_req(REQ_DELETE, 0, 0));
        wait_drain();
    endtask

    task automatic test_result_backpressure();
        int n;
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        recv_hold_cycles = LONG_HOLD;
        // keep offering while the receiver holds off so the input stalls
        for (n = 0; n < 12; n++) begin
            send_req(random_req(16));
        end
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        int target_len;
        target_len = 0;
        for (phase = 0; phase < 4; phase++) begin
            send_idle_en = (phase == 0 || phase == 2);
            recv_idle_en = (phase == 0 || phase == 3);
            for (n = 0; n < RANDOM_PHASE; n++) begin
                if ((n % 40) == 0) begin
                    target_len = ($urandom_range(0, 3) == 0) ? CAPACITY : $urandom_range(0, 20);
                end
                send_req(random_req(target_len));
            end
            wait_drain();
        end
    endtask

    // Accept results with random stalls and compare each with the oldest expectation.
    initial begin : result_checker
        int       stall;
        ple_out_t want;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (recv_hold_cycles > 0) begin
                stall = recv_hold_cycles;
                recv_hold_cycles = 0;
            end else begin
                stall = recv_idle_en ? $urandom_range(0, 11) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_data.status);
                    error_count++;
                end
                if (m_data.out_value !== want.out_value) begin
                    $error("out_value: expected %0d, actual %0d",
                           want.out_value, m_data.out_value);
                    error_count++;
                end
                if (m_data.out_position !== want.out_position) begin
                    $error("out_position: expected %0d, actual %0d",
                           want.out_position, m_data.out_position);
                    error_count++;
                end
                if (m_data.list_empty !== want.list_empty) begin
                    $error("list_empty: expected %0d, actual %0d",
                           want.list_empty, m_data.list_empty);
                    error_count++;
                end
                if (m_data.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, m_data.entry_count);
                    error_count++;
                end
            end
        end
    end

    // End the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_data           = '0;
        list_len         = 0;
        error_count      = 0;
        send_idle_en     = 1'b0;
        recv_idle_en     = 1'b0;
        recv_hold_cycles = 0;
        quiet_cycles     = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_and_small_list();
        test_fill_to_capacity();
        test_result_backpressure();
        test_random_traffic();

        wait_drain();
        repeat (DRAIN_SLACK) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ple_pkg.sv
hw/rtl/ple_dpath.sv
hw/rtl/ple_ctrl.sv
hw/rtl/positional_list_engine.sv
tb/tb.sv
